>>> rtl/pmfl_pkg.sv
`timescale 1ns / 1ps

package pmfl_pkg;

  // default sizes of the pair table
  localparam int SLOTS_DEF         = 64;
  localparam int HISTORY_DEPTH_DEF = 4;

  // field widths
  localparam int ACT_W    = 2;
  localparam int OWN_W    = 6;
  localparam int PART_W   = 7;
  localparam int TIME_W   = 32;
  localparam int GAP_W    = 17;
  localparam int SEC_W    = 16;

  // stream packing, lowest bit first
  localparam int OWN_LSB     = 0;
  localparam int PART_LSB    = OWN_LSB + OWN_W;
  localparam int NOW_LSB     = PART_LSB + PART_W;
  localparam int PLWT_LSB    = NOW_LSB + TIME_W;
  localparam int IN_TDATA_W  = 80;
  localparam int OUT_TDATA_W = 24;
  localparam int OUT_PAD_W   = OUT_TDATA_W - SEC_W - 2;

  // configuration port
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;
  localparam logic [SEC_W-1:0] WINDOW_RST = 16'd60;
  localparam logic [SEC_W-1:0] ANSWER_RST = 16'd60;

  // register select, taken from the word address bit
  typedef enum logic {
    REG_WINDOW = 1'b0,
    REG_ANSWER = 1'b1
  } reg_sel_t;

  typedef enum logic [ACT_W-1:0] {
    ACT_CHECK  = 2'd0,
    ACT_COMMIT = 2'd1,
    ACT_QUERY  = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } fsm_state_t;

  // controller to datapath
  typedef struct packed {
    logic clr_en;
    logic accept;
    logic exec;
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;
    logic out_free;
  } dp_sts_t;

endpackage

>>> rtl/pmfl_regs.sv
`timescale 1ns / 1ps

module pmfl_regs
  import pmfl_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready,
  output logic [SEC_W-1:0]  window_seconds,
  output logic [SEC_W-1:0]  answer_window
);

  logic [SEC_W-1:0] window_r, window_nxt;
  logic [SEC_W-1:0] answer_r, answer_nxt;
  logic             wr_en;
  reg_sel_t         sel;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign sel        = reg_sel_t'(cfg_paddr[2]);

  // register write decode
  always_comb begin
    window_nxt = window_r;
    answer_nxt = answer_r;
    if (wr_en) begin
      unique case (sel)
        REG_WINDOW: window_nxt = cfg_pwdata[SEC_W-1:0];
        REG_ANSWER: answer_nxt = cfg_pwdata[SEC_W-1:0];
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= WINDOW_RST;
      answer_r <= ANSWER_RST;
    end else begin
      window_r <= window_nxt;
      answer_r <= answer_nxt;
    end
  end

  // read mux
  always_comb begin
    unique case (sel)
      REG_WINDOW: cfg_prdata = {{(CFG_DW-SEC_W){1'b0}}, window_r};
      REG_ANSWER: cfg_prdata = {{(CFG_DW-SEC_W){1'b0}}, answer_r};
      default:    cfg_prdata = '0;
    endcase
  end

  assign window_seconds = window_r;
  assign answer_window  = answer_r;

endmodule

>>> rtl/pmfl_ctrl.sv
`timescale 1ns / 1ps

module pmfl_ctrl
  import pmfl_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  input  dp_sts_t  sts,
  output logic     in_tready,
  output ctl_cmd_t cmd
);

  fsm_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (sts.clr_last) state_nxt = ST_IDLE;
      ST_IDLE:  if (in_tvalid) state_nxt = ST_EXEC;
      ST_EXEC:  if (sts.out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  // outputs
  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_CLEAR: cmd.clr_en = 1'b1;
      ST_IDLE: begin
        in_tready  = 1'b1;
        cmd.accept = in_tvalid;
      end
      ST_EXEC:  cmd.exec = sts.out_free;
      default:  ;
    endcase
  end

endmodule

>>> rtl/pmfl_dp.sv
`timescale 1ns / 1ps

module pmfl_dp
  import pmfl_pkg::*;
#(
  parameter int SLOTS         = SLOTS_DEF,
  parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  ctl_cmd_t               cmd,
  output dp_sts_t                sts,
  input  action_t                action,
  input  logic [OWN_W-1:0]       own_slot,
  input  logic [PART_W-1:0]      partner_slot,
  input  logic [TIME_W-1:0]      now,
  input  logic [TIME_W-1:0]      partner_last_write_time,
  input  logic [SEC_W-1:0]       window_seconds,
  input  logic [SEC_W-1:0]       answer_window,
  input  logic                   out_tready,
  output logic                   out_tvalid,
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  localparam int NGAPS = HISTORY_DEPTH - 1;
  localparam int DEPTH = SLOTS * SLOTS;
  localparam int AW    = $clog2(DEPTH);
  localparam int MW    = 1 + TIME_W + GAP_W * NGAPS;
  localparam int TW    = GAP_W + $clog2(HISTORY_DEPTH);

  // pair table: valid bit, last send time, gaps
  logic [MW-1:0]     entry_mem_r [DEPTH];
  logic [MW-1:0]     mem_q_r;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [MW-1:0]     wr_data;
  logic [AW-1:0]     clr_cnt_r;

  // item registers
  action_t           act_r;
  logic              inside_r;
  logic [AW-1:0]     idx_r;
  logic [TIME_W-1:0] now_r;
  logic [TIME_W-1:0] plwt_r;

  // pending record
  logic [TIME_W-1:0] pend_time_r;
  logic [GAP_W-1:0]  pend_gaps_r [NGAPS];
  logic [MW-2-TIME_W:0] pend_flat;

  // output register
  logic                   out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;

  // address of the accepted item
  logic              in_inside;
  logic [AW-1:0]     chk_idx;
  logic [AW-1:0]     qry_idx;
  logic [AW-1:0]     rd_addr;

  assign in_inside = (32'(own_slot) < SLOTS) && (32'(partner_slot) < SLOTS);
  assign chk_idx   = AW'(own_slot) * AW'(SLOTS) + AW'(partner_slot);
  assign qry_idx   = AW'(partner_slot) * AW'(SLOTS) + AW'(own_slot);
  assign rd_addr   = (action == ACT_QUERY) ? qry_idx : chk_idx;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      act_r    <= action;
      inside_r <= in_inside;
      idx_r    <= rd_addr;
      now_r    <= now;
      plwt_r   <= partner_last_write_time;
    end
  end

  // clearing pass counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr_en) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  // memory write: clearing pass or commit
  always_comb begin
    for (int i = 0; i < NGAPS; i++) begin
      pend_flat[i*GAP_W +: GAP_W] = pend_gaps_r[i];
    end
  end

  assign wr_en   = cmd.clr_en | (cmd.exec & (act_r == ACT_COMMIT) & inside_r);
  assign wr_addr = cmd.clr_en ? clr_cnt_r : idx_r;
  assign wr_data = cmd.clr_en ? '0 : {1'b1, pend_time_r, pend_flat};

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry_mem_r[wr_addr] <= wr_data;
    end
    if (cmd.accept) begin
      mem_q_r <= entry_mem_r[rd_addr];
    end
  end

  // entry decode
  logic              ent_valid;
  logic [TIME_W-1:0] ent_time;
  logic [GAP_W-1:0]  empty_gap;

  assign ent_valid = inside_r & mem_q_r[MW-1];
  assign ent_time  = mem_q_r[MW-2 -: TIME_W];
  assign empty_gap = {1'b0, window_seconds} + 17'd1;

  // flood check: shifted record and wait
  logic              chk_empty;
  logic [TIME_W-1:0] chk_t;
  logic [TIME_W-1:0] diff;
  logic [GAP_W-1:0]  chk_g [NGAPS];
  logic [GAP_W-1:0]  diff_sat;
  logic [GAP_W-1:0]  sft0;
  logic [TW-1:0]     total;
  logic [TW-1:0]     win_ext;
  logic [SEC_W-1:0]  wait_sec;

  always_comb begin
    chk_empty = !ent_valid || (ent_time > now_r);
    chk_t     = chk_empty ? '0 : ent_time;
    for (int i = 0; i < NGAPS; i++) begin
      chk_g[i] = chk_empty ? empty_gap : mem_q_r[i*GAP_W +: GAP_W];
    end
    diff     = now_r - chk_t;
    sft0     = (diff > {16'b0, window_seconds}) ? empty_gap : diff[GAP_W-1:0];
    // saturated span keeps the compare against a 16-bit window exact
    diff_sat = (|diff[TIME_W-1:GAP_W]) ? '1 : diff[GAP_W-1:0];
    total    = TW'(diff_sat);
    for (int i = 0; i < NGAPS; i++) begin
      total = total + TW'(chk_g[i]);
    end
    win_ext  = TW'(window_seconds);
    wait_sec = (total >= win_ext) ? '0 : SEC_W'(win_ext - total);
  end

  // answer query
  logic [TIME_W-1:0] qry_t;
  logic              may_ans;

  always_comb begin
    qry_t   = ent_valid ? ent_time : '0;
    may_ans = (qry_t > plwt_r) &&
              ((qry_t > now_r) || ((now_r - qry_t) <= {16'b0, answer_window}));
  end

  // pending record update on check
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_time_r <= '0;
      for (int i = 0; i < NGAPS; i++) begin
        pend_gaps_r[i] <= '0;
      end
    end else if (cmd.exec && (act_r == ACT_CHECK)) begin
      pend_time_r        <= now_r;
      pend_gaps_r[NGAPS-1] <= sft0;
      for (int i = 0; i < NGAPS - 1; i++) begin
        pend_gaps_r[i] <= chk_g[i+1];
      end
    end
  end

  // result beat
  logic [SEC_W-1:0] res_wait;
  logic             res_may;

  always_comb begin
    res_wait = '0;
    res_may  = 1'b0;
    case (act_r)
      ACT_CHECK: res_wait = wait_sec;
      ACT_QUERY: res_may  = may_ans;
      default:   ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.exec) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      out_data_r <= {{OUT_PAD_W{1'b0}}, ~inside_r, res_may, res_wait};
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;
  assign sts.out_free = !out_valid_r || out_tready;
  assign sts.clr_last = (clr_cnt_r == AW'(DEPTH - 1));

endmodule

>>> rtl/pairwise_message_flood_limiter.sv
`timescale 1ns / 1ps

// Per sender/receiver pair flood limiter. Each pair owns one row of a
// SLOTS*SLOTS entry table holding its last send time and the HISTORY_DEPTH-1
// gaps before it. A check beat (tuser 0) answers with the seconds to wait and
// stages a pending record, a commit beat (tuser 1) writes that record to the
// own->partner row, a query beat (tuser 2) reports whether the partner may be
// answered. Every beat gives exactly one result beat. The accept cycle reads
// the table row into a register; the execute state then evaluates it, writes
// back on commit and loads the output register, waiting while the output
// register is full. The next item is accepted only after that. After reset a
// clearing pass writes every row empty, during which in_tready stays low;
// register writes are taken at any time.
module pairwise_message_flood_limiter
  import pmfl_pkg::*;
#(
  parameter int SLOTS         = SLOTS_DEF,
  parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // input stream
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // own_slot, partner_slot, now, partner_last_write_time, zero fill
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // action
  input  logic [ACT_W-1:0]       in_tuser,
  // result stream
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // wait_seconds, may_answer, out_of_range, zero fill
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // configuration
  input  logic                   cfg_psel,
  input  logic                   cfg_penable,
  input  logic                   cfg_pwrite,
  input  logic [CFG_AW-1:0]      cfg_paddr,
  input  logic [CFG_DW-1:0]      cfg_pwdata,
  output logic [CFG_DW-1:0]      cfg_prdata,
  output logic                   cfg_pready
);

  ctl_cmd_t         cmd;
  dp_sts_t          sts;
  logic [SEC_W-1:0] window_seconds;
  logic [SEC_W-1:0] answer_window;

  pmfl_regs u_regs (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_psel       (cfg_psel),
    .cfg_penable    (cfg_penable),
    .cfg_pwrite     (cfg_pwrite),
    .cfg_paddr      (cfg_paddr),
    .cfg_pwdata     (cfg_pwdata),
    .cfg_prdata     (cfg_prdata),
    .cfg_pready     (cfg_pready),
    .window_seconds (window_seconds),
    .answer_window  (answer_window)
  );

  pmfl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .sts       (sts),
    .in_tready (in_tready),
    .cmd       (cmd)
  );

  pmfl_dp #(
    .SLOTS         (SLOTS),
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_dp (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .cmd                     (cmd),
    .sts                     (sts),
    .action                  (action_t'(in_tuser)),
    .own_slot                (in_tdata[OWN_LSB +: OWN_W]),
    .partner_slot            (in_tdata[PART_LSB +: PART_W]),
    .now                     (in_tdata[NOW_LSB +: TIME_W]),
    .partner_last_write_time (in_tdata[PLWT_LSB +: TIME_W]),
    .window_seconds          (window_seconds),
    .answer_window           (answer_window),
    .out_tready              (out_tready),
    .out_tvalid              (out_tvalid),
    .out_tdata               (out_tdata)
  );

endmodule

>>> rtl/pmfl_chk.sv
`timescale 1ns / 1ps

module pmfl_chk
  import pmfl_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed while stalled");

  // one item in flight: no accept in the cycle after an accept
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while an item is in flight");

  // a result never carries both a wait and an answer grant
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[SEC_W-1:0] == '0) || !out_tdata[SEC_W])
    else $error("wait and may_answer both set");

  // an out-of-range pair is never granted an answer
  a_oor: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[SEC_W+1] |-> !out_tdata[SEC_W])
    else $error("may_answer set for out-of-range pair");

endmodule

bind pairwise_message_flood_limiter pmfl_chk u_pmfl_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
